FILE: rtl/core/ttw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the toroidal tile window recenter unit
// no dependencies

package ttw_pkg;

  localparam int unsigned WINDOW_SIDE_DEF = 5;
  localparam int unsigned COORD_W         = 16;
  localparam int unsigned CENTER_W        = 32;
  localparam int unsigned SLOT_IDX_W      = 6;
  localparam int unsigned CFG_IDX_W       = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 2'd1;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_MOVE = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0]  coord_x;
    logic [COORD_W-1:0]  coord_y;
    logic [CENTER_W-1:0] off_x;
    logic [CENTER_W-1:0] off_y;
  } slot_t;

  typedef struct packed {
    logic [COORD_W-1:0] lo_x;
    logic [COORD_W-1:0] hi_x;
    logic [COORD_W-1:0] lo_y;
    logic [COORD_W-1:0] hi_y;
  } bounds_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BND_LO,
    ST_BND_HI,
    ST_SLOT,
    ST_WAIT,
    ST_PUSH,
    ST_FLUSH
  } state_e;

endpackage

FILE: rtl/core/ttw_if.sv
`timescale 1ns / 1ps
// channel interfaces: input items, fetch requests, configuration writes
// depends on ttw_pkg

interface ttw_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [ttw_pkg::CENTER_W-1:0]  center_x;
  logic [ttw_pkg::CENTER_W-1:0]  center_y;
  modport source (output valid, operation, center_x, center_y, input ready);
  modport sink   (input valid, operation, center_x, center_y, output ready);
endinterface

interface ttw_out_if;
  logic                           valid;
  logic                           ready;
  logic [ttw_pkg::SLOT_IDX_W-1:0] slot_index;
  logic [ttw_pkg::COORD_W-1:0]    fetch_x;
  logic [ttw_pkg::COORD_W-1:0]    fetch_y;
  logic                           last;
  modport source (output valid, slot_index, fetch_x, fetch_y, last, input ready);
  modport sink   (input valid, slot_index, fetch_x, fetch_y, last, output ready);
endinterface

interface ttw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ttw_pkg::CFG_IDX_W-1:0] index;
  logic [ttw_pkg::COORD_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ttw_wrap_div.sv
`timescale 1ns / 1ps
// serial wrap unit: signed 32 bit value modulo a 16 bit world size, one bit a cycle
// depends on ttw_pkg

module ttw_wrap_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ttw_pkg::CENTER_W-1:0]  value_i,
  input  logic [ttw_pkg::COORD_W-1:0]   modulus_i,
  output logic                          done_o,
  output logic [ttw_pkg::COORD_W-1:0]   result_o
);

  localparam int unsigned CW = ttw_pkg::COORD_W;
  localparam int unsigned VW = ttw_pkg::CENTER_W;
  localparam int unsigned NW = $clog2(VW + 1);

  logic          busy_q, done_q, neg_q;
  logic [NW-1:0] cnt_q;
  logic [VW-1:0] dvd_q;
  logic [CW-1:0] rem_q, mod_q;
  logic [CW:0]   trial;

  // shift in the next dividend bit
  assign trial = {rem_q, dvd_q[VW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= NW'(VW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == NW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mod_q <= (modulus_i == '0) ? CW'(1) : modulus_i;
      neg_q <= value_i[VW-1];
      dvd_q <= value_i[VW-1] ? (~value_i + 1'b1) : value_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[VW-2:0], 1'b0};
      if (trial >= {1'b0, mod_q}) begin
        rem_q <= CW'(trial - {1'b0, mod_q});
      end else begin
        rem_q <= trial[CW-1:0];
      end
    end
  end

  // negative values fold back into 0 .. size-1
  assign result_o = (neg_q && rem_q != '0) ? (mod_q - rem_q) : rem_q;
  assign done_o   = done_q;

endmodule

FILE: rtl/core/ttw_cell.sv
`timescale 1ns / 1ps
// one window slot cell of the rotating ring, with its inside-bounds test
// depends on ttw_pkg

module ttw_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  ttw_pkg::slot_t   slot_i,
  input  ttw_pkg::bounds_t bounds_i,
  output ttw_pkg::slot_t   slot_o,
  output logic             inside_o
);

  ttw_pkg::slot_t slot_q;
  logic in_x, in_y;

  // take the neighbour's slot on a shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (shift_i) begin
      slot_q <= slot_i;
    end
  end

  // bounds may straddle the wrap point
  always_comb begin
    if (bounds_i.lo_x < bounds_i.hi_x) begin
      in_x = (slot_q.coord_x >= bounds_i.lo_x) && (slot_q.coord_x <= bounds_i.hi_x);
    end else begin
      in_x = (slot_q.coord_x >= bounds_i.lo_x) || (slot_q.coord_x <= bounds_i.hi_x);
    end
    if (bounds_i.lo_y < bounds_i.hi_y) begin
      in_y = (slot_q.coord_y >= bounds_i.lo_y) && (slot_q.coord_y <= bounds_i.hi_y);
    end else begin
      in_y = (slot_q.coord_y >= bounds_i.lo_y) || (slot_q.coord_y <= bounds_i.hi_y);
    end
  end

  assign slot_o   = slot_q;
  assign inside_o = in_x && in_y;

endmodule

FILE: rtl/core/toroidal_tile_window_recenter_unit.sv
`timescale 1ns / 1ps
// top level: window slot ring, sequencer, wrap units and output staging
// depends on ttw_pkg, ttw_if, ttw_cell, ttw_wrap_div
//
// usage
//   in_i   : items with operation, center_x, center_y; taken only while idle
//   out_o  : one fetch request per refilled slot, in slot order, last marks
//            the final request of an item
//   cfg_i  : world width (index 0) and height (index 1), always ready
// timing
//   slots sit in a ring of cells and rotate past a head cell, one slot per
//   step; each refetched slot runs the two serial wrap units (one quotient
//   bit a cycle), so a load runs them once per slot, and a move adds two
//   wrap runs for the bounds plus one per slot outside them, while a slot
//   inside only rotates; a move to an unchanged center is dropped at once
// reset
//   clears the ring, the last centers and the sizes (to 1); no request pending
// stall
//   one request is held in a pending register and one in the output
//   register; the sequencer waits while both are full

module toroidal_tile_window_recenter_unit #(
  parameter int unsigned WINDOW_SIDE = ttw_pkg::WINDOW_SIDE_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ttw_in_if.sink    in_i,
  ttw_out_if.source out_o,
  ttw_cfg_if.sink   cfg_i
);

  localparam int unsigned SLOTS = WINDOW_SIDE * WINDOW_SIDE;
  localparam int unsigned HALF  = WINDOW_SIDE / 2;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned RW    = $clog2(WINDOW_SIDE);
  localparam int unsigned CW    = ttw_pkg::COORD_W;
  localparam int unsigned VW    = ttw_pkg::CENTER_W;
  localparam int unsigned IW    = ttw_pkg::SLOT_IDX_W;

  ttw_pkg::state_e state_q, state_d;

  logic [CW-1:0] world_w_q, world_h_q;
  logic [VW-1:0] last_cx_q, last_cy_q, cx_q, cy_q;
  logic          op_q;
  logic [SW-1:0] cnt_q;
  logic [RW-1:0] col_q, row_q;
  ttw_pkg::bounds_t bounds_q;

  logic [CW-1:0] res_x_q, res_y_q;
  logic          pend_v_q;
  logic [IW-1:0] pend_idx_q;
  logic [CW-1:0] pend_x_q, pend_y_q;
  logic          out_v_q, out_last_q;
  logic [IW-1:0] out_idx_q;
  logic [CW-1:0] out_x_q, out_y_q;

  ttw_pkg::slot_t ring [SLOTS];
  ttw_pkg::slot_t head_next;
  logic [SLOTS-1:0] in_bnd;

  logic          accept, move_eq, can_push, last_slot;
  logic          start, shift, push_out, flush_out, take_pend, end_item;
  logic [VW-1:0] opnd_x, opnd_y, ox, oy, dx, dy;
  logic          done_x, done_y;
  logic [CW-1:0] wx, wy;

  assign accept    = in_i.valid && in_i.ready;
  assign move_eq   = (in_i.operation == ttw_pkg::OP_MOVE) &&
                     (in_i.center_x == last_cx_q) && (in_i.center_y == last_cy_q);
  assign can_push  = !out_v_q || out_o.ready;
  assign last_slot = (cnt_q == SW'(SLOTS - 1));
  assign ox        = VW'(col_q) - VW'(HALF);
  assign oy        = VW'(row_q) - VW'(HALF);
  assign dx        = cx_q - last_cx_q;
  assign dy        = cy_q - last_cy_q;

  // ring of slot cells, head at position zero
  for (genvar g = 0; g < SLOTS; g++) begin : g_ring
    ttw_pkg::slot_t nb;
    if (g == SLOTS - 1) begin : g_tail
      assign nb = head_next;
    end else begin : g_mid
      assign nb = ring[g+1];
    end
    ttw_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .slot_i   (nb),
      .bounds_i (bounds_q),
      .slot_o   (ring[g]),
      .inside_o (in_bnd[g])
    );
  end

  // serial wrap units, one per axis
  ttw_wrap_div u_wrap_x (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start), .value_i (opnd_x),
    .modulus_i (world_w_q), .done_o (done_x), .result_o (wx)
  );
  ttw_wrap_div u_wrap_y (
    .clk_i (clk_i), .rst_ni (rst_ni), .start_i (start), .value_i (opnd_y),
    .modulus_i (world_h_q), .done_o (done_y), .result_o (wy)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttw_pkg::ST_IDLE: begin
        if (accept && !move_eq) begin
          state_d = (in_i.operation == ttw_pkg::OP_MOVE) ? ttw_pkg::ST_BND_LO
                                                         : ttw_pkg::ST_SLOT;
        end
      end
      ttw_pkg::ST_BND_LO: if (done_x) state_d = ttw_pkg::ST_BND_HI;
      ttw_pkg::ST_BND_HI: if (done_x) state_d = ttw_pkg::ST_SLOT;
      ttw_pkg::ST_SLOT: begin
        if (op_q == ttw_pkg::OP_LOAD || !in_bnd[0]) begin
          state_d = ttw_pkg::ST_WAIT;
        end else if (last_slot) begin
          state_d = ttw_pkg::ST_FLUSH;
        end
      end
      ttw_pkg::ST_WAIT: if (done_x) state_d = ttw_pkg::ST_PUSH;
      ttw_pkg::ST_PUSH: begin
        if (!pend_v_q || can_push) begin
          state_d = last_slot ? ttw_pkg::ST_FLUSH : ttw_pkg::ST_SLOT;
        end
      end
      ttw_pkg::ST_FLUSH: if (!pend_v_q || can_push) state_d = ttw_pkg::ST_IDLE;
      default: state_d = ttw_pkg::ST_IDLE;
    endcase
  end

  // control strobes and wrap operands
  always_comb begin
    start     = 1'b0;
    shift     = 1'b0;
    push_out  = 1'b0;
    flush_out = 1'b0;
    take_pend = 1'b0;
    end_item  = 1'b0;
    opnd_x    = cx_q - ring[0].off_x;
    opnd_y    = cy_q - ring[0].off_y;
    unique case (state_q)
      ttw_pkg::ST_IDLE: begin
        opnd_x = in_i.center_x - VW'(HALF);
        opnd_y = in_i.center_y - VW'(HALF);
        start  = accept && !move_eq && (in_i.operation == ttw_pkg::OP_MOVE);
      end
      ttw_pkg::ST_BND_LO: begin
        opnd_x = cx_q + VW'(HALF);
        opnd_y = cy_q + VW'(HALF);
        start  = done_x;
      end
      ttw_pkg::ST_SLOT: begin
        if (op_q == ttw_pkg::OP_LOAD) begin
          opnd_x = cx_q + ox;
          opnd_y = cy_q + oy;
          start  = 1'b1;
        end else if (!in_bnd[0]) begin
          start = 1'b1;
        end else begin
          shift = 1'b1;
        end
      end
      ttw_pkg::ST_PUSH: begin
        if (!pend_v_q || can_push) begin
          shift     = 1'b1;
          take_pend = 1'b1;
          push_out  = pend_v_q;
        end
      end
      ttw_pkg::ST_FLUSH: begin
        if (!pend_v_q || can_push) begin
          flush_out = pend_v_q;
          end_item  = 1'b1;
        end
      end
      ttw_pkg::ST_BND_HI, ttw_pkg::ST_WAIT: begin
      end
      default: begin
      end
    endcase
  end

  // value written back into the ring tail for the head slot
  always_comb begin
    head_next = ring[0];
    if (state_q == ttw_pkg::ST_PUSH) begin
      head_next.coord_x = res_x_q;
      head_next.coord_y = res_y_q;
      if (op_q == ttw_pkg::OP_LOAD) begin
        head_next.off_x = ox;
        head_next.off_y = oy;
      end else begin
        head_next.off_x = ~ring[0].off_x + 1'b1;
        head_next.off_y = ~ring[0].off_y + 1'b1;
      end
    end else begin
      head_next.off_x = ring[0].off_x - dx;
      head_next.off_y = ring[0].off_y - dy;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttw_pkg::ST_IDLE;
      world_w_q <= CW'(1);
      world_h_q <= CW'(1);
      last_cx_q <= '0;
      last_cy_q <= '0;
      cnt_q     <= '0;
      col_q     <= '0;
      row_q     <= '0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          ttw_pkg::REG_WORLD_WIDTH:  world_w_q <= cfg_i.data;
          ttw_pkg::REG_WORLD_HEIGHT: world_h_q <= cfg_i.data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        cnt_q <= '0;
        col_q <= '0;
        row_q <= '0;
      end else if (shift) begin
        cnt_q <= cnt_q + 1'b1;
        if (col_q == RW'(WINDOW_SIDE - 1)) begin
          col_q <= '0;
          row_q <= row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      if (end_item) begin
        last_cx_q <= cx_q;
        last_cy_q <= cy_q;
      end
      if (take_pend) begin
        pend_v_q <= 1'b1;
      end else if (flush_out) begin
        pend_v_q <= 1'b0;
      end
      if (push_out || flush_out) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= in_i.operation;
      cx_q <= in_i.center_x;
      cy_q <= in_i.center_y;
    end
    if (state_q == ttw_pkg::ST_BND_LO && done_x) begin
      bounds_q.lo_x <= wx;
      bounds_q.lo_y <= wy;
    end
    if (state_q == ttw_pkg::ST_BND_HI && done_x) begin
      bounds_q.hi_x <= wx;
      bounds_q.hi_y <= wy;
    end
    if (state_q == ttw_pkg::ST_WAIT && done_y) begin
      res_x_q <= wx;
      res_y_q <= wy;
    end
    if (push_out || flush_out) begin
      out_idx_q  <= pend_idx_q;
      out_x_q    <= pend_x_q;
      out_y_q    <= pend_y_q;
      out_last_q <= flush_out;
    end
    if (take_pend) begin
      pend_idx_q <= IW'(cnt_q);
      pend_x_q   <= res_x_q;
      pend_y_q   <= res_y_q;
    end
  end

  assign in_i.ready       = (state_q == ttw_pkg::ST_IDLE);
  assign cfg_i.ready      = 1'b1;
  assign out_o.valid      = out_v_q;
  assign out_o.slot_index = out_idx_q;
  assign out_o.fetch_x    = out_x_q;
  assign out_o.fetch_y    = out_y_q;
  assign out_o.last       = out_last_q;

endmodule
